// ===== sv/fixed_block_pool_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_macros
// assertion macros shared by the checker of the block pool allocator
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define FBPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("block pool allocator: same-cycle check failed");

// next-cycle implication, disabled during reset
`define FBPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("block pool allocator: next-cycle check failed");

`endif

// ===== sv/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fbpa_pkg
// shared constants, types and helpers of the block pool allocator
// ----------------------------------------------------------------------------
`default_nettype none

package fbpa_pkg;

	localparam int MAX_BLOCKS = 256;
	localparam int LINK_AW    = $clog2(MAX_BLOCKS);

	localparam int CNT_W      = 9;
	localparam int LOG2_W     = 4;
	localparam int ADDR_W     = 32;
	localparam int IDX_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int OUT_FIELDS_W = IDX_W + ADDR_W + CNT_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [CNT_W-1:0]  RST_BLOCK_COUNT = CNT_W'(256);
	localparam logic [LOG2_W-1:0] RST_SIZE_LOG2   = LOG2_W'(12);
	localparam logic [ADDR_W-1:0] RST_BASE        = '0;
	localparam logic [CNT_W-1:0]  CNT_SAT         = '1;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BLOCK_COUNT     = 2'd0,
		CFG_BLOCK_SIZE_LOG2 = 2'd1,
		CFG_BASE_ADDRESS    = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	typedef struct packed {
		logic [CNT_W-1:0]  eff_count;
		logic [LOG2_W-1:0] size_log2;
		logic [ADDR_W-1:0] base;
		logic              restart;
		logic [CNT_W-1:0]  restart_count;
	} cfg_t;

	// block count clipped to the link memory depth
	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] count);
		if (32'(count) > MAX_BLOCKS)
			return CNT_W'(MAX_BLOCKS);
		return count;
	endfunction

endpackage

`default_nettype wire

// ===== sv/fixed_block_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// fixed-size block pool with a lazily built free list in a link memory
// ----------------------------------------------------------------------------
// usage
//   request words enter on the s_ group: s_tuser is the request kind
//   (allocate or free), s_tdata the byte address of a block to free
//   every request gives exactly one result word on the m_ group: m_tuser
//   says granted, m_tdata carries block index, block address, free count
//   an allocate links the next untouched block, pops the list head and
//   fetches the link of that head from the link memory
//   a request is accepted, then looked up: the accept cycle writes or reads the link
//   memory, the lookup state picks up its registered read data; the next
//   request is taken in the cycle after the lookup, so requests never overlap
//   the result shows on m_tvalid after the lookup state ends
//   the result sits in an output register; a stalled receiver holds it
//   there, one more request is still taken, and its lookup waits until the
//   register is emptied
//   reset (arst_n low) or any defined config write restarts the pool: all blocks
//   free, head at block 0, no link written yet; no clearing pass is needed
//   config writes are single-cycle and only legal while no request is open
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_pool_allocator (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// request channel
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [fbpa_pkg::ADDR_W-1:0]         s_tdata,  // [31:0] free_address
	input  wire logic                                s_tuser,  // [0] req_type
	// result channel
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic      [fbpa_pkg::OUT_TDATA_W-1:0]    m_tdata,  // [7:0] block_index,
	                                                            // [39:8] block_address,
	                                                            // [48:40] free_count,
	                                                            // [55:49] zero
	output logic                                     m_tuser,  // [0] granted
	// configuration write port
	input  wire logic                                cfg_we,
	input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [fbpa_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int AW = fbpa_pkg::LINK_AW;
	localparam int CW = fbpa_pkg::CNT_W;

	fbpa_pkg::cfg_t   cfg;
	fbpa_pkg::state_t state_q, state_d;

	// pool state
	logic [CW-1:0] init_q;       // next untouched block
	logic [CW-1:0] free_q;       // free block count
	logic [CW-1:0] head_q;       // free list head
	logic          head_valid_q;

	// request held across the lookup cycle
	logic                        granted_s1;
	logic [fbpa_pkg::IDX_W-1:0]  idx_s1;
	logic [fbpa_pkg::ADDR_W-1:0] addr_s1;
	logic                        follow_s1;   // head moves to the fetched link
	logic                        fwd_s1;      // link came from the accept cycle's write
	logic [CW-1:0]               fwd_data_s1;
	logic                        oor_s1;      // head beyond the link memory

	// output register
	logic                            m_valid_q;
	logic [fbpa_pkg::OUT_TDATA_W-1:0] m_data_q;
	logic                            m_user_q;

	// link memory port
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [CW-1:0] ram_wdata, ram_rdata;

	logic accept, done;
	logic is_alloc, lazy_go, pop_go, fidx_ok, fwd_hit;
	logic [fbpa_pkg::ADDR_W-1:0] off, fidx, alloc_addr;
	logic [CW-1:0] link_in, free_dec, new_head;

	fbpa_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fbpa_link_ram #(
		.AW (AW),
		.DW (CW)
	) u_link (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer: accept, then a lookup state that waits for the output register
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		done     = 1'b0;
		unique case (state_q)
			fbpa_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = fbpa_pkg::ST_LOOKUP;
			end
			fbpa_pkg::ST_LOOKUP: begin
				done = !m_valid_q || m_tready;
				if (done)
					state_d = fbpa_pkg::ST_IDLE;
			end
			default: begin
				state_d = fbpa_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= fbpa_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	assign accept   = s_tvalid && s_tready;
	assign is_alloc = (s_tuser == fbpa_pkg::REQ_ALLOC);

	// allocate side: lazy link step and pop
	assign lazy_go    = init_q < cfg.eff_count;
	assign pop_go     = free_q != '0;
	assign free_dec   = free_q - CW'(1);
	assign alloc_addr = cfg.base + (fbpa_pkg::ADDR_W'(head_q) << cfg.size_log2);
	assign fwd_hit    = lazy_go && (init_q == head_q);

	// free side: address to block index
	assign off     = s_tdata - cfg.base;
	assign fidx    = off >> cfg.size_log2;
	assign fidx_ok = fidx < fbpa_pkg::ADDR_W'(cfg.eff_count);
	assign link_in = head_valid_q ? head_q : cfg.eff_count;

	always_comb begin
		ram_we    = accept && (is_alloc ? lazy_go : fidx_ok);
		ram_waddr = is_alloc ? AW'(init_q) : AW'(fidx);
		ram_wdata = is_alloc ? (init_q + CW'(1)) : link_in;
		ram_re    = accept && is_alloc && pop_go;
		ram_raddr = AW'(head_q);
	end

	// link of the popped head: forwarded, read back, or zero beyond the memory
	always_comb begin
		if (oor_s1)
			new_head = '0;
		else if (fwd_s1)
			new_head = fwd_data_s1;
		else
			new_head = ram_rdata;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			granted_s1  <= is_alloc ? pop_go : fidx_ok;
			idx_s1      <= (is_alloc && pop_go) ? head_q[fbpa_pkg::IDX_W-1:0] : '0;
			addr_s1     <= (is_alloc && pop_go) ? alloc_addr : '0;
			follow_s1   <= is_alloc && pop_go && (free_dec != '0);
			fwd_s1      <= fwd_hit;
			fwd_data_s1 <= init_q + CW'(1);
			oor_s1      <= 32'(head_q) >= fbpa_pkg::MAX_BLOCKS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q       <= '0;
			free_q       <= fbpa_pkg::eff_count(fbpa_pkg::RST_BLOCK_COUNT);
			head_q       <= '0;
			head_valid_q <= 1'b1;
		end else if (cfg.restart) begin
			init_q       <= '0;
			free_q       <= cfg.restart_count;
			head_q       <= '0;
			head_valid_q <= 1'b1;
		end else if (accept) begin
			if (is_alloc) begin
				if (lazy_go)
					init_q <= init_q + CW'(1);
				if (pop_go) begin
					free_q <= free_dec;
					if (free_dec == '0)
						head_valid_q <= 1'b0;
				end
			end else if (fidx_ok) begin
				head_q       <= CW'(fidx);
				head_valid_q <= 1'b1;
				if (free_q != fbpa_pkg::CNT_SAT)
					free_q <= free_q + CW'(1);
			end
		end else if (done && follow_s1) begin
			head_q <= new_head;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (done)
			m_valid_q <= 1'b1;
		else if (m_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (done) begin
			m_user_q <= granted_s1;
			m_data_q <= fbpa_pkg::OUT_TDATA_W'({free_q, addr_s1, idx_s1});
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

endmodule

`default_nettype wire

// ===== sv/fbpa_link_ram.sv =====
// ----------------------------------------------------------------------------
// fbpa_link_ram
// single write, single read link memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_link_ram #(
	parameter int AW = 8,
	parameter int DW = 9
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/fbpa_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// fbpa_cfg_regs
// configuration registers and pool restart request
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_cfg_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [fbpa_pkg::CFG_DATA_W-1:0]    cfg_data,
	output fbpa_pkg::cfg_t                          cfg
);

	logic [fbpa_pkg::CNT_W-1:0]  block_count_q;
	logic [fbpa_pkg::LOG2_W-1:0] size_log2_q;
	logic [fbpa_pkg::ADDR_W-1:0] base_q;
	logic                        hit;
	logic [fbpa_pkg::CNT_W-1:0]  count_d;

	always_comb begin
		hit     = 1'b0;
		count_d = block_count_q;
		unique case (cfg_index)
			fbpa_pkg::CFG_BLOCK_COUNT: begin
				hit     = 1'b1;
				count_d = cfg_data[fbpa_pkg::CNT_W-1:0];
			end
			fbpa_pkg::CFG_BLOCK_SIZE_LOG2,
			fbpa_pkg::CFG_BASE_ADDRESS: begin
				hit = 1'b1;
			end
			default: begin
				hit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= fbpa_pkg::RST_BLOCK_COUNT;
			size_log2_q   <= fbpa_pkg::RST_SIZE_LOG2;
			base_q        <= fbpa_pkg::RST_BASE;
		end else if (cfg_we) begin
			if (cfg_index == fbpa_pkg::CFG_BLOCK_COUNT)
				block_count_q <= cfg_data[fbpa_pkg::CNT_W-1:0];
			if (cfg_index == fbpa_pkg::CFG_BLOCK_SIZE_LOG2)
				size_log2_q <= cfg_data[fbpa_pkg::LOG2_W-1:0];
			if (cfg_index == fbpa_pkg::CFG_BASE_ADDRESS)
				base_q <= cfg_data[fbpa_pkg::ADDR_W-1:0];
		end
	end

	always_comb begin
		cfg.eff_count     = fbpa_pkg::eff_count(block_count_q);
		cfg.size_log2     = size_log2_q;
		cfg.base          = base_q;
		cfg.restart       = cfg_we && hit;
		cfg.restart_count = fbpa_pkg::eff_count(count_d);
	end

endmodule

`default_nettype wire

// ===== sv/fbpa_checker.sv =====
// ----------------------------------------------------------------------------
// fbpa_checker
// port-level checks of the block pool allocator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "fixed_block_pool_allocator_macros.svh"

module fbpa_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_tvalid,
	input wire logic                             s_tready,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [fbpa_pkg::OUT_TDATA_W-1:0] m_tdata,
	input wire logic                             m_tuser
);

	localparam int HI = fbpa_pkg::IDX_W + fbpa_pkg::ADDR_W;

	// a refused request carries no block
	`FBPA_ASSERT_NOW(a_refused_no_block, clk, arst_n, m_tvalid && !m_tuser, m_tdata[HI-1:0] == '0)

	// pad bits above the free count stay zero
	`FBPA_ASSERT_NOW(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[fbpa_pkg::OUT_TDATA_W-1:HI+fbpa_pkg::CNT_W] == '0)

	// the link lookup closes the request port after an accept
	`FBPA_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// a stalled result holds
	`FBPA_ASSERT_NEXT(a_result_holds, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);

`default_nettype wire
